// ===== sv/four_digit_led_serial_driver_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the LED serial driver
// Shared property shapes used by the top-level checks.
// ----------------------------------------------------------------------------
`ifndef FOUR_DIGIT_LED_SERIAL_DRIVER_MACROS_SVH
`define FOUR_DIGIT_LED_SERIAL_DRIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LDD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define LDD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== sv/ldd_pkg.sv =====
// ----------------------------------------------------------------------------
// ldd_pkg
// Shared constants, types and helpers for the LED serial driver.
// ----------------------------------------------------------------------------
`default_nettype none

package ldd_pkg;

   localparam int DIGITS_DEF = 4;

   localparam logic [7:0] ADDR_CMD_RST = 8'h03;
   localparam logic [7:0] DISP_CMD_RST = 8'h11;

   localparam logic CSR_ADDR_CMD = 1'b0;
   localparam logic CSR_DISP_CMD = 1'b1;

   localparam int VALUE_W = 16;
   localparam int DIGIT_W = 4;

   // Slot position within a byte: eight data slots, then the ack slot.
   localparam int SLOT_W = 4;
   localparam logic [SLOT_W-1:0] SLOT_ACK = 4'd8;

   // Divide by ten: q = (v * 52429) >> 19, exact for any 16-bit v.
   localparam logic [16:0] DIV10_MUL = 17'd52429;
   localparam int DIV10_SHIFT = 19;

   typedef struct packed {
      logic data_bit;
      logic ack_slot;
      logic start_before;
      logic stop_after;
      logic last;
   } slot_type;

   function automatic int ldd_pow10(input int n);
      int p;
      p = 1;
      for (int i = 0; i < n; i++) begin
         p = p * 10;
      end
      return p;
   endfunction

   function automatic logic [7:0] ldd_seg(input logic [DIGIT_W-1:0] d);
      logic [7:0] s;
      case (d)
         4'd0:    s = 8'hFD;
         4'd1:    s = 8'h61;
         4'd2:    s = 8'hDB;
         4'd3:    s = 8'hF3;
         4'd4:    s = 8'h67;
         4'd5:    s = 8'hB7;
         4'd6:    s = 8'hBF;
         4'd7:    s = 8'hE1;
         4'd8:    s = 8'hFF;
         4'd9:    s = 8'hF7;
         default: s = 8'hFD;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== sv/ldd_front.sv =====
// ----------------------------------------------------------------------------
// ldd_front
// Accepts values, saturates them and splits them into decimal digits.
// ----------------------------------------------------------------------------
`default_nettype none

module ldd_front
   import ldd_pkg::*;
#(
   parameter int DIGITS = DIGITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_push,
   output logic                           req_full,
   input  wire logic [VALUE_W-1:0]        req_value,
   output logic                           q_push,
   output logic [DIGITS*DIGIT_W-1:0]      q_data,
   input  wire logic                      q_full
);

   localparam int CNT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam logic [31:0] LIMIT = 32'(ldd_pow10(DIGITS) - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]                  state_ff, state_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [VALUE_W-1:0]          val_ff, val_in;
   logic [DIGITS*DIGIT_W-1:0]   digs_ff, digs_in;

   logic                        accept;
   logic [VALUE_W-1:0]          sat_value;
   logic [VALUE_W+16:0]         prod;
   logic [VALUE_W-1:0]          quot;
   logic [VALUE_W-1:0]          rem;

   assign req_full = !((state_ff == ST_IDLE) || ((state_ff == ST_HOLD) && !q_full));
   assign accept   = req_push && !req_full;
   assign q_push   = (state_ff == ST_HOLD) && !q_full;
   assign q_data   = digs_ff;

   assign sat_value = (32'(req_value) > LIMIT) ? LIMIT[VALUE_W-1:0] : req_value;

   // One digit per cycle, least significant first, shifted in at the top.
   assign prod = 33'(val_ff) * 33'(DIV10_MUL);
   assign quot = VALUE_W'(prod >> DIV10_SHIFT);
   assign rem  = val_ff - ((quot << 3) + (quot << 1));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      val_in   = val_ff;
      digs_in  = digs_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CONV;
               cnt_in   = '0;
               val_in   = sat_value;
            end
         end
         ST_CONV: begin
            val_in  = quot;
            digs_in = (digs_ff >> DIGIT_W);
            digs_in[DIGITS*DIGIT_W-1 -: DIGIT_W] = rem[DIGIT_W-1:0];
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIGITS - 1)) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!q_full) begin
               if (accept) begin
                  state_in = ST_CONV;
                  cnt_in   = '0;
                  val_in   = sat_value;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      val_ff  <= val_in;
      digs_ff <= digs_in;
   end

endmodule

`default_nettype wire

// ===== sv/ldd_queue.sv =====
// ----------------------------------------------------------------------------
// ldd_queue
// Two-entry queue of digit words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ldd_queue #(
   parameter int WIDTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== sv/ldd_back.sv =====
// ----------------------------------------------------------------------------
// ldd_back
// Serializes one digit word into the bus slots of both frames.
// ----------------------------------------------------------------------------
`default_nettype none

module ldd_back
   import ldd_pkg::*;
#(
   parameter int DIGITS = DIGITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [7:0]                addr_cmd,
   input  wire logic [7:0]                disp_cmd,
   input  wire logic                      q_empty,
   input  wire logic [DIGITS*DIGIT_W-1:0] q_data,
   output logic                           q_pop,
   output logic                           out_valid,
   output slot_type                       out_slot,
   input  wire logic                      out_pop
);

   localparam int BYTE_W = $clog2(DIGITS + 2);
   localparam logic [BYTE_W-1:0] BYTE_LAST = BYTE_W'(DIGITS + 1);
   localparam logic [BYTE_W-1:0] BYTE_SEG_LAST = BYTE_W'(DIGITS);

   logic                        busy_ff, busy_in;
   logic [BYTE_W-1:0]           byte_ff, byte_in;
   logic [SLOT_W-1:0]           slot_ff, slot_in;
   logic [DIGITS*DIGIT_W-1:0]   digs_ff, digs_in;
   slot_type                    out_ff;
   logic                        out_valid_ff;

   logic                        advance, final_slot, load, is_ack;
   logic [7:0]                  cur_byte;
   slot_type                    cur_slot;

   assign advance    = busy_ff && (!out_valid_ff || out_pop);
   assign is_ack     = (slot_ff == SLOT_ACK);
   assign final_slot = (byte_ff == BYTE_LAST) && is_ack;
   assign load       = !q_empty && (!busy_ff || (advance && final_slot));
   assign q_pop      = load;

   always_comb begin
      if (byte_ff == '0) begin
         cur_byte = addr_cmd;
      end else if (byte_ff == BYTE_LAST) begin
         cur_byte = disp_cmd;
      end else begin
         cur_byte = ldd_seg(digs_ff[DIGITS*DIGIT_W-1 -: DIGIT_W]);
      end
   end

   always_comb begin
      cur_slot.data_bit     = is_ack ? cur_byte[0] : cur_byte[~slot_ff[2:0]];
      cur_slot.ack_slot     = is_ack;
      cur_slot.start_before = (slot_ff == '0) && ((byte_ff == '0) || (byte_ff == BYTE_LAST));
      cur_slot.stop_after   = is_ack && ((byte_ff == BYTE_SEG_LAST) || (byte_ff == BYTE_LAST));
      cur_slot.last         = final_slot;
   end

   always_comb begin
      busy_in = busy_ff;
      byte_in = byte_ff;
      slot_in = slot_ff;
      digs_in = digs_ff;
      if (load) begin
         busy_in = 1'b1;
         byte_in = '0;
         slot_in = '0;
         digs_in = q_data;
      end else if (advance) begin
         if (final_slot) begin
            busy_in = 1'b0;
         end else if (is_ack) begin
            slot_in = '0;
            byte_in = byte_ff + 1'b1;
            // advance to the next digit once a segment byte is done
            if (byte_ff != '0) begin
               digs_in = digs_ff << DIGIT_W;
            end
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         byte_ff      <= '0;
         slot_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         byte_ff <= byte_in;
         slot_ff <= slot_in;
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (out_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
      digs_ff <= digs_in;
      if (advance) begin
         out_ff <= cur_slot;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_slot  = out_ff;

endmodule

`default_nettype wire

// ===== sv/four_digit_led_serial_driver.sv =====
// ----------------------------------------------------------------------------
// four_digit_led_serial_driver
// Turns a number into the two-wire bus slots that drive a 4-digit LED display.
// ----------------------------------------------------------------------------
//
//   channel   ports                               direction  transfer
//   request   req_push / req_full / req_value     in         push & !full
//   response  rsp_pop / rsp_empty / rsp_*         out        pop & !empty
//   config    csr_write_en / csr_index / csr_wdata in        write_en high
//
// Each value yields 9*(DIGITS+2) slots, 54 at the default, one per cycle while
// the reader pops every cycle; the slot output register sets this rate.
// Digit conversion in the front overlaps the previous value's serialization
// through a two-entry queue.
// Reset clears all control state and loads the command registers (0x03, 0x11).
// Stalls on either side are independent: a full queue holds the front, an
// unpopped slot holds the back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "four_digit_led_serial_driver_macros.svh"

module four_digit_led_serial_driver
   import ldd_pkg::*;
#(
   parameter int DIGITS = DIGITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request side
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic [VALUE_W-1:0] req_value,
   // response side
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic                    rsp_data_bit,
   output logic                    rsp_ack_slot,
   output logic                    rsp_start_before,
   output logic                    rsp_stop_after,
   output logic                    rsp_last,
   // register writes
   input  wire logic               csr_write_en,
   input  wire logic               csr_index,
   input  wire logic [7:0]         csr_wdata
);

   localparam int DIGS_W = DIGITS * DIGIT_W;

   // Command registers; the user must write them only while idle (not enforced here), so the back reads them live.
   logic [7:0] addr_cmd_ff, addr_cmd_in;
   logic [7:0] disp_cmd_ff, disp_cmd_in;

   logic              q_push, q_full, q_pop, q_empty;
   logic [DIGS_W-1:0] q_wdata, q_rdata;
   logic              out_valid;
   slot_type          out_slot;

   always_comb begin
      addr_cmd_in = addr_cmd_ff;
      disp_cmd_in = disp_cmd_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_ADDR_CMD: addr_cmd_in = csr_wdata;
            CSR_DISP_CMD: disp_cmd_in = csr_wdata;
            default: begin
               addr_cmd_in = addr_cmd_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_cmd_ff <= ADDR_CMD_RST;
         disp_cmd_ff <= DISP_CMD_RST;
      end else begin
         addr_cmd_ff <= addr_cmd_in;
         disp_cmd_ff <= disp_cmd_in;
      end
   end

   // Front: accept, saturate, split into digits.
   ldd_front #(
      .DIGITS (DIGITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_value (req_value),
      .q_push    (q_push),
      .q_data    (q_wdata),
      .q_full    (q_full)
   );

   // Hold finished digit words while the back is still sending.
   ldd_queue #(
      .WIDTH (DIGS_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   // Back: walk the bytes of both frames, one slot per cycle while the reader pops.
   ldd_back #(
      .DIGITS (DIGITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .addr_cmd  (addr_cmd_ff),
      .disp_cmd  (disp_cmd_ff),
      .q_empty   (q_empty),
      .q_data    (q_rdata),
      .q_pop     (q_pop),
      .out_valid (out_valid),
      .out_slot  (out_slot),
      .out_pop   (rsp_pop)
   );

   assign rsp_empty        = !out_valid;
   assign rsp_data_bit     = out_slot.data_bit;
   assign rsp_ack_slot     = out_slot.ack_slot;
   assign rsp_start_before = out_slot.start_before;
   assign rsp_stop_after   = out_slot.stop_after;
   assign rsp_last         = out_slot.last;

   // The closing slot of a run is always an ack slot that ends a frame.
   `LDD_ASSERT_IMPL(a_last_is_ack_stop, clock, reset, !rsp_empty && rsp_last, rsp_ack_slot && rsp_stop_after)
   // A start condition never precedes an ack slot.
   `LDD_ASSERT_IMPL(a_start_not_ack, clock, reset, !rsp_empty && rsp_start_before, !rsp_ack_slot)
   // Popping a word from the queue leaves room for the front next cycle.
   `LDD_ASSERT_NEXT(a_pop_frees_queue, clock, reset, q_pop && !q_push, !q_full)

endmodule

`default_nettype wire
